// File: hw/rtl/telemetry_running_mean_history_assert.svh
// Assertion macros for the telemetry running mean history block.
`ifndef TELEMETRY_RUNNING_MEAN_HISTORY_ASSERT_SVH
`define TELEMETRY_RUNNING_MEAN_HISTORY_ASSERT_SVH
// Implication checked every clock, quiet during reset.
`define TRMH_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define TRMH_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/trmh_pkg.sv
// Shared constants for the telemetry running mean history block.
package trmh_pkg;
  localparam int DefHistoryDepth = 64;
  localparam logic [15:0] NegCurrentStart = 16'd61440;
  localparam logic [13:0] SocFull = 14'd10000;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam int NumMeans = 7;
endpackage

// File: hw/rtl/telemetry_running_mean_history.sv
// Telemetry running mean history: one item per transaction, one result per transaction.
// Each item is processed by a single shared restoring divider, one quotient bit per
// cycle. Eight divisions are run back to back: the state of charge first, then the
// seven means. Each has one setup/multiply step, 64 quotient bits and one store step;
// the state of charge division gives zero without quotient bits when the maximum
// capacity is zero. The next transaction is accepted only once the block is back in
// idle, which it reaches on the same edge as out_valid is set, and in_stall is high
// until then. The result is held in an output register until taken, so the next item
// can be worked on while it waits. Only the final step of that next item waits while
// the previous result is still stalled. The history ring is a write-only memory of
// HISTORY_DEPTH rows written at the period-end item.
module telemetry_running_mean_history #(
  parameter int HISTORY_DEPTH = trmh_pkg::DefHistoryDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [15:0]         max_cap_high,
  input  logic [15:0]         max_cap_low,
  input  logic [15:0]         cap_high,
  input  logic [15:0]         cap_low,
  input  logic [15:0]         load_current_raw,
  input  logic [15:0]         battery_volts_raw,
  input  logic [15:0]         alternator_watts,
  input  logic [15:0]         solar_watts,
  input  logic [15:0]         alternator_day_ah,
  input  logic [15:0]         solar_day_charge_ah,
  input  logic [15:0]         solar_day_discharge_ah,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                snapshot_written,
  output logic [7:0]          history_slot,
  output logic [7:0]          history_fill,
  output logic [13:0]         soc_mean,
  output logic [15:0]         volts_mean,
  output logic signed [32:0]  load_mean_mw,
  output logic [15:0]         alternator_mean,
  output logic [15:0]         solar_mean,
  output logic [15:0]         charged_mean,
  output logic [15:0]         discharged_mean
);
  import trmh_pkg::*;

  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_NEXT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [3:0] job;          // 0 = soc, 1..7 = means
  logic [6:0] bit_cnt;
  logic [63:0] num;         // dividend magnitude, shifted out MSB first
  logic [63:0] quo;
  logic [31:0] den;
  logic [32:0] rem;
  logic        neg;

  // sample registers
  logic        kind_r;
  logic [30:0] maxc, capc;
  logic [13:0] soc_x;
  logic [15:0] volts_x, alt_x, sol_x, chg_x, dis_x;
  logic signed [32:0] load_x;
  // means
  logic [13:0] m_soc;
  logic [15:0] m_volts, m_alt, m_sol, m_chg, m_dis;
  logic signed [32:0] m_load;
  logic [15:0] count;
  logic [HW-1:0] head;
  logic [7:0] fill;

  logic [62:0] hist_bat [HISTORY_DEPTH];
  logic [63:0] hist_src [HISTORY_DEPTH];

  logic [16:0] chg_sum;
  logic signed [16:0] amps;
  logic signed [33:0] load_w;
  logic        done_fire;
  logic [32:0] rem_sh;
  logic [63:0] prod;
  logic signed [49:0] sprod;
  logic [15:0] sel_m, sel_x;
  logic [63:0] quo_next;
  logic [32:0] rem_next;

  assign chg_sum = {1'b0, alternator_day_ah} + {1'b0, solar_day_charge_ah};
  assign amps = (load_current_raw < NegCurrentStart) ? $signed({1'b0, load_current_raw})
                                                     : $signed({1'b1, load_current_raw});
  assign load_w = amps * $signed({1'b0, battery_volts_raw});
  assign in_stall = (state != S_IDLE);
  assign done_fire = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    case (job)
      4'd2: begin sel_m = m_volts; sel_x = volts_x; end
      4'd4: begin sel_m = m_alt;   sel_x = alt_x;   end
      4'd5: begin sel_m = m_sol;   sel_x = sol_x;   end
      4'd6: begin sel_m = m_chg;   sel_x = chg_x;   end
      4'd7: begin sel_m = m_dis;   sel_x = dis_x;   end
      default: begin sel_m = {2'b00, m_soc}; sel_x = {2'b00, soc_x}; end
    endcase
    prod = {32'd0, sel_m} * {48'd0, count};
    sprod = $signed(m_load) * $signed({1'b0, count});
    rem_sh = {rem[31:0], num[63]};
    if (rem_sh >= {1'b0, den}) begin
      rem_next = rem_sh - {1'b0, den};
      quo_next = {quo[62:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      quo_next = {quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      m_soc <= '0; m_volts <= '0; m_load <= '0;
      m_alt <= '0; m_sol <= '0; m_chg <= '0; m_dis <= '0;
      count <= '0; head <= '0; fill <= '0;
    end else begin
      if (done_fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            kind_r <= kind;
            maxc <= {max_cap_high, max_cap_low[15:1]};
            capc <= {cap_high, cap_low[15:1]};
            volts_x <= battery_volts_raw;
            alt_x <= alternator_watts;
            sol_x <= solar_watts;
            chg_x <= chg_sum[16] ? CountMax : chg_sum[15:0];
            dis_x <= solar_day_discharge_ah;
            load_x <= load_w[32:0];
            job <= 4'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          bit_cnt <= 7'd64;
          rem <= '0;
          quo <= '0;
          neg <= 1'b0;
          if (job == 4'd0) begin
            num <= {33'd0, capc} * 64'd10000;
            den <= {1'b0, maxc};
          end else if (job == 4'd3) begin
            logic signed [50:0] t;
            t = 51'(sprod) + 51'(load_x);
            neg <= t[50];
            num <= t[50] ? 64'(-t) : 64'(t);
            den <= {16'd0, count} + 32'd1;
          end else begin
            num <= prod + {48'd0, sel_x};
            den <= {16'd0, count} + 32'd1;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (den == '0) begin
            quo <= '0;
            state <= S_NEXT;
          end else begin
            rem <= rem_next;
            quo <= quo_next;
            num <= {num[62:0], 1'b0};
            bit_cnt <= bit_cnt - 7'd1;
            if (bit_cnt == 7'd1) state <= S_NEXT;
          end
        end
        S_NEXT: begin
          case (job)
            4'd0: soc_x <= (quo > 64'(SocFull)) ? SocFull : quo[13:0];
            4'd1: m_soc <= quo[13:0];
            4'd2: m_volts <= quo[15:0];
            4'd3: m_load <= neg ? -$signed(quo[32:0]) : $signed(quo[32:0]);
            4'd4: m_alt <= quo[15:0];
            4'd5: m_sol <= quo[15:0];
            4'd6: m_chg <= quo[15:0];
            default: m_dis <= quo[15:0];
          endcase
          if (job == 4'd7) state <= S_DONE;
          else begin
            job <= job + 4'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            snapshot_written <= kind_r;
            history_slot <= kind_r ? 8'(head) : 8'd0;
            soc_mean <= m_soc; volts_mean <= m_volts; load_mean_mw <= m_load;
            alternator_mean <= m_alt; solar_mean <= m_sol;
            charged_mean <= m_chg; discharged_mean <= m_dis;
            if (kind_r) begin
              head <= (32'(head) + 1 >= HISTORY_DEPTH) ? '0 : head + HW'(1);
              if (32'(fill) < HISTORY_DEPTH - 1) begin
                fill <= fill + 8'd1;
                history_fill <= fill + 8'd1;
              end else history_fill <= fill;
              m_soc <= soc_x; m_volts <= volts_x; m_load <= load_x;
              m_alt <= alt_x; m_sol <= sol_x; m_chg <= chg_x; m_dis <= dis_x;
              count <= 16'd1;
            end else begin
              history_fill <= fill;
              if (count != CountMax) count <= count + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire && kind_r) begin
      hist_bat[head] <= {m_load, m_volts, m_soc};
      hist_src[head] <= {m_dis, m_chg, m_sol, m_alt};
    end
  end

  logic unused_hist;
  assign unused_hist = ^{hist_bat[0], hist_src[0], NumMeans[0]};
endmodule

// File: hw/rtl/trmh_checker.sv
// Port-level checker for the telemetry running mean history block, with bind.
`include "telemetry_running_mean_history_assert.svh"
module trmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        snapshot_written,
  input logic [7:0]  history_slot,
  input logic [13:0] soc_mean
);
  `TRMH_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(soc_mean), "stalled result not held")
  `TRMH_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "not busy after accept")
  `TRMH_ASSERT_IMP(a_slot_zero, clk, rst, out_valid && !snapshot_written, history_slot == 8'd0, "slot set without snapshot")
  `TRMH_ASSERT_IMP(a_soc_range, clk, rst, out_valid, soc_mean <= 14'd10000, "soc mean above full")
endmodule

bind telemetry_running_mean_history trmh_checker u_trmh_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .snapshot_written(snapshot_written),
  .history_slot(history_slot), .soc_mean(soc_mean)
);

// File: tb/tb_telemetry_running_mean_history.sv
// Self-checking testbench for the telemetry running mean history block.

typedef struct {
  logic        snap;
  logic [7:0]  slot;
  logic [7:0]  fill;
  logic [13:0] soc;
  logic [15:0] volts;
  logic [32:0] load;
  logic [15:0] alt;
  logic [15:0] sol;
  logic [15:0] chg;
  logic [15:0] dis;
} summary_t;

class trmh_scoreboard;
  summary_t pending[$];
  longint unsigned m_soc, m_volts, m_alt, m_sol, m_chg, m_dis;
  longint m_load;
  longint unsigned count;
  int unsigned head, fill;
  int depth;
  int errors;

  function new(int d);
    depth = d;
    m_soc = 0; m_volts = 0; m_alt = 0; m_sol = 0; m_chg = 0; m_dis = 0;
    m_load = 0; count = 0; head = 0; fill = 0; errors = 0;
  endfunction

  function longint unsigned fold_u(longint unsigned m, longint unsigned x);
    return (m * count + x) / (count + 1);
  endfunction

  function void note_sample(logic kind, logic [15:0] mch, logic [15:0] mcl,
                            logic [15:0] ch, logic [15:0] cl, logic [15:0] cur,
                            logic [15:0] v, logic [15:0] aw, logic [15:0] sw,
                            logic [15:0] aah, logic [15:0] sah, logic [15:0] dah);
    longint unsigned maxc, cap, soc, chg;
    longint amps, load, cnt;
    summary_t e;
    maxc = ({48'd0, mch} << 15) | ({48'd0, mcl} >> 1);
    cap = ({48'd0, ch} << 15) | ({48'd0, cl} >> 1);
    soc = 0;
    if (maxc != 0) begin
      soc = cap * 10000 / maxc;
      if (soc > 10000) soc = 10000;
    end
    amps = (cur < 16'd61440) ? longint'(cur) : longint'(cur) - 65536;
    load = amps * longint'(v);
    chg = aah + sah;
    if (chg > 65535) chg = 65535;
    cnt = count;
    m_soc = fold_u(m_soc, soc);
    m_volts = fold_u(m_volts, v);
    m_load = (m_load * cnt + load) / (cnt + 1);
    m_alt = fold_u(m_alt, aw);
    m_sol = fold_u(m_sol, sw);
    m_chg = fold_u(m_chg, chg);
    m_dis = fold_u(m_dis, dah);
    if (count < 65535) count++;
    e.soc = m_soc[13:0]; e.volts = m_volts[15:0]; e.load = m_load[32:0];
    e.alt = m_alt[15:0]; e.sol = m_sol[15:0]; e.chg = m_chg[15:0]; e.dis = m_dis[15:0];
    e.snap = kind; e.slot = '0;
    if (kind) begin
      e.slot = head[7:0];
      head = (head + 1 >= depth) ? 0 : head + 1;
      if (fill < depth - 1) fill++;
      m_soc = soc; m_volts = v; m_load = load; m_alt = aw; m_sol = sw;
      m_chg = chg; m_dis = dah; count = 1;
    end
    e.fill = fill[7:0];
    pending.push_back(e);
  endfunction

  function void mismatch(string f, longint unsigned x, longint unsigned a);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, f, x, a);
  endfunction

  function void check_result(summary_t a);
    summary_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, actual soc %0h", $time, a.soc);
      return;
    end
    e = pending.pop_front();
    if (a.snap !== e.snap) mismatch("snapshot_written", e.snap, a.snap);
    if (a.slot !== e.slot) mismatch("history_slot", e.slot, a.slot);
    if (a.fill !== e.fill) mismatch("history_fill", e.fill, a.fill);
    if (a.soc !== e.soc) mismatch("soc_mean", e.soc, a.soc);
    if (a.volts !== e.volts) mismatch("volts_mean", e.volts, a.volts);
    if (a.load !== e.load) mismatch("load_mean_mw", e.load, a.load);
    if (a.alt !== e.alt) mismatch("alternator_mean", e.alt, a.alt);
    if (a.sol !== e.sol) mismatch("solar_mean", e.sol, a.sol);
    if (a.chg !== e.chg) mismatch("charged_mean", e.chg, a.chg);
    if (a.dis !== e.dis) mismatch("discharged_mean", e.dis, a.dis);
  endfunction
endclass

module tb_telemetry_running_mean_history;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = trmh_pkg::DefHistoryDepth;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic kind = 0;
  logic [15:0] max_cap_high = 0, max_cap_low = 0, cap_high = 0, cap_low = 0;
  logic [15:0] load_current_raw = 0, battery_volts_raw = 0;
  logic [15:0] alternator_watts = 0, solar_watts = 0;
  logic [15:0] alternator_day_ah = 0, solar_day_charge_ah = 0, solar_day_discharge_ah = 0;
  logic snapshot_written;
  logic [7:0] history_slot, history_fill;
  logic [13:0] soc_mean;
  logic [15:0] volts_mean, alternator_mean, solar_mean, charged_mean, discharged_mean;
  logic signed [32:0] load_mean_mw;

  trmh_scoreboard sb = new(Depth);
  bit quiet_tail = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  telemetry_running_mean_history #(.HISTORY_DEPTH(Depth)) dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_sample(logic k, logic [15:0] mch, logic [15:0] mcl,
                             logic [15:0] ch, logic [15:0] cl, logic [15:0] cur,
                             logic [15:0] v, logic [15:0] aw, logic [15:0] sw,
                             logic [15:0] aah, logic [15:0] sah, logic [15:0] dah);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    kind <= k; max_cap_high <= mch; max_cap_low <= mcl; cap_high <= ch; cap_low <= cl;
    load_current_raw <= cur; battery_volts_raw <= v; alternator_watts <= aw;
    solar_watts <= sw; alternator_day_ah <= aah; solar_day_charge_ah <= sah;
    solar_day_discharge_ah <= dah;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(k, mch, mcl, ch, cl, cur, v, aw, sw, aah, sah, dah);
    @(negedge clk);
  endtask

  task automatic send_random(logic k);
    logic [15:0] mch, ch, cur;
    mch = 16'($urandom);
    ch = $urandom_range(0, 1) ? (mch >> $urandom_range(0, 3)) : 16'($urandom);
    case ($urandom_range(0, 5))
      0: mch = 16'd0;
      1: mch = 16'($urandom_range(0, 3));
      default: ;
    endcase
    cur = $urandom_range(0, 1) ? 16'($urandom_range(61440, 65535)) : 16'($urandom);
    send_sample(k, mch, 16'($urandom), ch, 16'($urandom), cur, 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  // result side
  always @(posedge clk) begin
    summary_t a;
    if (!rst && out_valid && !out_stall) begin
      a.snap = snapshot_written; a.slot = history_slot; a.fill = history_fill;
      a.soc = soc_mean; a.volts = volts_mean; a.load = load_mean_mw;
      a.alt = alternator_mean; a.sol = solar_mean; a.chg = charged_mean;
      a.dis = discharged_mean;
      sb.check_result(a);
    end
  end

  initial begin
    int n;
    @(negedge clk);
    while (!stim_done) begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        long_hold = 0;
        out_stall <= 0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
      @(negedge clk);
    end
  end

  initial begin
    int i, t;
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd61440, 16'hFFFF, 16'd0,
                16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(1'b0, 16'd100, 16'd0, 16'd500, 16'd0, 16'hFFFF, 16'd120, 16'd1, 16'd2,
                16'h8000, 16'h8000, 16'd5);
    send_sample(1'b1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd61439, 16'd1, 16'hAAAA, 16'h5555,
                16'hFFFF, 16'd0, 16'h5555);
    send_sample(1'b0, 16'h8000, 16'h5555, 16'h4000, 16'hAAAA, 16'd61440, 16'hFFFF,
                16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(1'b1, 16'h1, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                16'h0, 16'h0);
    for (i = 0; i < Depth + 4; i++) send_random(1'b1);
    long_hold = 1;
    for (i = 0; i < 8; i++) send_random(1'b0);
    for (i = 0; i < 1820; i++) begin
      if (i == 600) begin
        in_valid <= 0;
        t = 0;
        while (sb.pending.size() != 0 && t < 200000) begin
          @(negedge clk);
          t++;
        end
      end
      if (i == 1600) quiet_tail = 1;
      send_random($urandom_range(0, 15) == 0);
    end
    in_valid <= 0;
    t = 0;
    while (sb.pending.size() != 0 && t < 200000) begin
      @(negedge clk);
      t++;
    end
    stim_done = 1;
    repeat (600) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/trmh_pkg.sv
hw/rtl/telemetry_running_mean_history.sv
hw/rtl/trmh_checker.sv
tb/tb_telemetry_running_mean_history.sv
